/* rtl/core/lcg_pkg.sv */
// Package for the linear chirp generator: widths, types, register indexes
// and the elaboration-time build of the quarter-wave sine table.
// No dependencies.
package lcg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int COUNT_BITS      = 24;

    localparam int QSIZE         = 1 << TABLE_ADDR_BITS;
    localparam int QADDR_BITS    = TABLE_ADDR_BITS + 1;
    localparam int TOP_BITS      = TABLE_ADDR_BITS + 2;
    localparam int MAG_BITS      = 14;
    localparam int SAMPLE_BITS   = 15;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int SCOUNT_BITS   = 24;

    localparam logic [MAG_BITS-1:0] AMP = 14'd16383;

    localparam logic [63:0] ONE_Q30     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_STEP     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_DECREMENT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_COUNT   = 2'd2;

    typedef logic [PHASE_BITS-1:0]         t_phase;
    typedef logic [COUNT_BITS-1:0]         t_count;
    typedef logic [QADDR_BITS-1:0]         t_qaddr;
    typedef logic [MAG_BITS-1:0]           t_qmag;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CFG_DATA_BITS-1:0]      t_cfg_data;
    typedef logic [CFG_IDX_BITS-1:0]       t_cfg_idx;
    typedef t_qmag                         t_qtab [0:QSIZE];

    // sideband that travels with a sample through the lookup pipe
    typedef struct packed {
        logic neg;
        logic act;
        logic last;
    } t_tag;

    // Q30 Horner series for sin on [0, pi/2], scaled to AMP and truncated
    function automatic t_qtab build_qtab();
        t_qtab       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        for (int n = 0; n < QSIZE; n++) begin
            x  = (64'(n) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            p  = ((x2 * t) >> 30) / 64'd156;
            t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
            p  = ((x2 * t) >> 30) / 64'd110;
            t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
            p  = ((x2 * t) >> 30) / 64'd72;
            t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
            p  = ((x2 * t) >> 30) / 64'd42;
            t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
            p  = ((x2 * t) >> 30) / 64'd20;
            t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
            p  = ((x2 * t) >> 30) / 64'd6;
            t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
            tab[n] = MAG_BITS'(((((x * t) >> 30) * 64'(AMP))) >> 30);
        end
        tab[QSIZE] = AMP;
        return tab;
    endfunction

endpackage

/* rtl/core/lcg_sine_rom.sv */
// Quarter-wave sine ROM with registered read data.
// Depends on lcg_pkg for the table contents and widths.
module lcg_sine_rom (
    input  logic           i_clk,
    input  logic           i_en,
    input  lcg_pkg::t_qaddr i_addr,
    output lcg_pkg::t_qmag  o_mag
);
    import lcg_pkg::*;

    localparam t_qtab QuarterRom = build_qtab();

    t_qmag r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= QuarterRom[i_addr];
        end
    end

    assign o_mag = r_mag;

endmodule

/* rtl/core/linear_chirp_generator.sv */
// Linear down-chirp DDS: phase accumulator, quadrant fold, sine ROM lookup.
// Requests pass stage A (ROM address), then stage B (ROM data). Throughput:
// one request per cycle unless i_ready stalls, set by phase/step and ROM port.
// Reset (synchronous, active low) clears the pipe, phase, step, count and
// running flag; start_step/step_decrement reset to 0, sample_count to 1.
// Depends on lcg_pkg and lcg_sine_rom.
module linear_chirp_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  lcg_pkg::t_cfg_idx   i_cfg_idx,
    input  lcg_pkg::t_cfg_data  i_cfg_data,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_start_req,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output lcg_pkg::t_sample    o_sample,
    output logic                o_active,
    output logic                o_last
);
    import lcg_pkg::*;

    logic [CFG_DATA_BITS-1:0] r_start_step;
    logic [CFG_DATA_BITS-1:0] r_step_dec;
    logic [SCOUNT_BITS-1:0]   r_sample_count;

    t_phase r_phase,   n_phase;
    t_phase r_step,    n_step;
    t_count r_left,    n_left;
    logic   r_running, n_running;

    logic   r_a_valid;
    t_qaddr r_a_addr;
    t_tag   r_a_tag;
    logic   r_b_valid;
    t_tag   r_b_tag;

    logic                en_a, en_b, acc, run, last_hit;
    t_count              cnt_cfg, cnt_start;
    t_phase              cur_phase, cur_step;
    t_count              cur_left;
    logic [TOP_BITS-1:0] top;
    logic [1:0]          quad;
    t_qaddr              idx, addr;
    t_qmag               rom_mag;
    t_sample             mag_s;

    // pipe advance: each stage moves when it is empty or the next one moves
    assign en_b    = !r_b_valid || i_ready;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;
    assign acc     = i_valid && en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_step   <= '0;
            r_step_dec     <= '0;
            r_sample_count <= SCOUNT_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_STEP:     r_start_step   <= i_cfg_data;
                CFG_STEP_DECREMENT: r_step_dec     <= i_cfg_data;
                CFG_SAMPLE_COUNT:   r_sample_count <= i_cfg_data[SCOUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cnt_cfg   = t_count'(r_sample_count);
        cnt_start = (cnt_cfg == '0) ? t_count'(1) : cnt_cfg;
        run       = i_start_req || r_running;
        cur_phase = i_start_req ? '0 : r_phase;
        cur_step  = i_start_req ? t_phase'(r_start_step) : r_step;
        cur_left  = i_start_req ? cnt_start : r_left;
        last_hit  = run && (cur_left == t_count'(1));

        // quadrant fold onto the quarter table
        top  = cur_phase[PHASE_BITS-1 -: TOP_BITS];
        quad = top[TOP_BITS-1 -: 2];
        idx  = {1'b0, top[TABLE_ADDR_BITS-1:0]};
        addr = quad[0] ? (QADDR_BITS'(QSIZE) - idx) : idx;

        n_phase   = r_phase;
        n_step    = r_step;
        n_left    = r_left;
        n_running = r_running;
        if (run) begin
            n_phase   = cur_phase + cur_step;
            n_step    = cur_step - t_phase'(r_step_dec);
            n_left    = cur_left - t_count'(1);
            n_running = !last_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_left    <= '0;
            r_running <= 1'b0;
        end else if (acc) begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_left    <= n_left;
            r_running <= n_running;
        end
    end

    // stage A: ROM address and sideband
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_addr <= addr;
            r_a_tag  <= '{neg: quad[1], act: run, last: last_hit};
        end
    end

    // stage B: ROM data lands here, held while the result waits
    lcg_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (en_b),
        .i_addr (r_a_addr),
        .o_mag  (rom_mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_tag <= r_a_tag;
        end
    end

    assign mag_s    = $signed({1'b0, rom_mag});
    assign o_valid  = r_b_valid;
    assign o_active = r_b_tag.act;
    assign o_last   = r_b_tag.last;
    assign o_sample = !r_b_tag.act ? '0 : (r_b_tag.neg ? -mag_s : mag_s);

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_active)
        else $error("last flagged on an idle sample");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> o_sample == '0)
        else $error("idle sample is not zero");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_start_req |=> r_running != r_a_tag.last)
        else $error("start request did not set up the chirp");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample) && $stable(o_last))
        else $error("stalled result changed");

endmodule

/* tb/linear_chirp_generator_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for linear_chirp_generator: a local chirp/DDS predictor
// checks every sample under random request gaps and result stalls.
// Depends on lcg_pkg and the linear_chirp_generator RTL.
module linear_chirp_generator_test;
    import lcg_pkg::*;

    localparam t_cfg_idx CFG_UNUSED_IDX = 2'd3;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

    typedef struct packed {
        t_sample sample;
        logic    active;
        logic    last;
    } t_chirp_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_idx   i_cfg_idx;
    t_cfg_data  i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    logic       i_start_req;
    logic       o_valid;
    logic       i_ready;
    t_sample    o_sample;
    logic       o_active;
    logic       o_last;

    linear_chirp_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample),
        .o_active    (o_active),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and register mirror
    t_qmag      quarter_mag [0:QSIZE];
    t_phase     chirp_phase;
    t_phase     chirp_step;
    t_count     chirp_left;
    bit         chirp_running;
    t_phase     cfg_start_step;
    t_phase     cfg_step_dec;
    t_count     cfg_count;

    t_chirp_out predicted_samples [$];
    t_chirp_out head_sample;

    int error_count;
    int requests_sent;
    int chirp_ticks;
    int samples_checked;
    int chirps_finished;
    int hold_cycles;
    bit no_gaps;

    function automatic void build_quarter_wave();
        logic [63:0] x;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] divs [0:5];
        divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        for (int n = 0; n < QSIZE; n++) begin
            x   = (64'(n) * QUARTER_TURN_Q30) >> TABLE_ADDR_BITS;
            sq  = (x * x) >> 30;
            acc = Q30_ONE;
            for (int k = 0; k < 6; k++) begin
                term = ((sq * acc) >> 30) / divs[k];
                acc  = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
            end
            quarter_mag[n] = MAG_BITS'(((((x * acc) >> 30) * 64'd16383)) >> 30);
        end
        quarter_mag[QSIZE] = AMP;
    endfunction

    function automatic t_sample sine_at(t_phase ph);
        logic [TOP_BITS-1:0] top;
        int    idx;
        t_qmag mag;
        top = ph[PHASE_BITS-1 -: TOP_BITS];
        idx = int'(top[TABLE_ADDR_BITS-1:0]);
        mag = top[TOP_BITS-2] ? quarter_mag[QSIZE - idx] : quarter_mag[idx];
        return top[TOP_BITS-1] ? t_sample'(-{1'b0, mag}) : t_sample'({1'b0, mag});
    endfunction

    // sample for the current phase, then move phase and step along the chirp
    function automatic t_chirp_out advance_chirp(bit start);
        t_chirp_out r;
        r = '0;
        if (start) begin
            chirp_phase   = '0;
            chirp_step    = cfg_start_step;
            chirp_left    = (cfg_count == '0) ? t_count'(1) : cfg_count;
            chirp_running = 1'b1;
        end
        if (chirp_running) begin
            r.sample    = sine_at(chirp_phase);
            r.active    = 1'b1;
            chirp_phase = chirp_phase + chirp_step;
            chirp_step  = chirp_step - cfg_step_dec;
            chirp_left  = chirp_left - t_count'(1);
            if (chirp_left == '0) begin
                r.last        = 1'b1;
                chirp_running = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(bit start);
        int gap;
        t_chirp_out r;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_start_req <= start;
        do @(posedge i_clk); while (!o_ready);
        r = advance_chirp(start);
        predicted_samples.push_back(r);
        requests_sent++;
        if (r.active)
            chirp_ticks++;
    endtask

    // stop requesting and wait for the pipe to empty
    task automatic settle_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (predicted_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, t_cfg_data val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_STEP:     cfg_start_step = val;
            CFG_STEP_DECREMENT: cfg_step_dec   = val;
            CFG_SAMPLE_COUNT:   cfg_count      = val[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_chirp(t_cfg_data step, t_cfg_data dec, t_cfg_data count);
        write_register(CFG_START_STEP, step);
        write_register(CFG_STEP_DECREMENT, dec);
        write_register(CFG_SAMPLE_COUNT, count);
    endtask

    task automatic test_idle_and_defaults();
        repeat (3) send_request(1'b0);
        send_request(1'b1);     // reset count of one: single flat sample
        send_request(1'b0);
        settle_pipeline();
    endtask

    task automatic test_quarter_turns();
        // quarter turn per sample hits +max, zero, -max and wraps the phase
        set_chirp(32'h4000_0000, 32'h0, 32'd5);
        send_request(1'b1);
        repeat (4) send_request(1'b0);
        settle_pipeline();
    endtask

    task automatic test_step_wrap();
        // all-ones decrement makes the step climb and wrap
        set_chirp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        settle_pipeline();
        // decrement larger than the step: step goes negative
        set_chirp(32'h0000_0100, 32'h0100_0000, 32'd4);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        settle_pipeline();
    endtask

    task automatic test_count_edges();
        write_register(CFG_SAMPLE_COUNT, 32'd0);
        send_request(1'b1);
        send_request(1'b0);
        settle_pipeline();
        // upper bits above the count width are dropped
        write_register(CFG_SAMPLE_COUNT, 32'hFF00_0002);
        send_request(1'b1);
        send_request(1'b0);
        settle_pipeline();
        // longest chirp, cut off by a new start
        set_chirp(32'h1234_5678, 32'h0000_1000, 32'h00FF_FFFF);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        settle_pipeline();
    endtask

    task automatic test_ignored_register();
        write_register(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        write_register(CFG_SAMPLE_COUNT, 32'd2);
        send_request(1'b1);
        send_request(1'b0);
        settle_pipeline();
    endtask

    task automatic configure_random();
        t_cfg_data step;
        t_cfg_data dec;
        t_cfg_data count;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            step = $urandom;
        else if (r < 85)
            step = $urandom_range(0, 1 << 20);
        else
            case ($urandom_range(0, 2))
                0: step = 32'h0;
                1: step = 32'hFFFF_FFFF;
                default: step = 32'h8000_0000;
            endcase
        r = $urandom_range(0, 99);
        if (r < 40)
            dec = $urandom_range(0, 65535);
        else if (r < 70)
            dec = $urandom;
        else if (r < 90)
            dec = 32'h0;
        else
            dec = 32'hFFFF_FFFF - $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 80)
            count = $urandom_range(1, 40);
        else if (r < 90)
            count = $urandom;
        else if (r < 95)
            count = 32'd0;
        else
            count = $urandom_range(41, 200);
        if ($urandom_range(0, 9) == 0)
            write_register(CFG_UNUSED_IDX, $urandom);
        set_chirp(step, dec, count);
    endtask

    task automatic test_random_chirps(int target);
        int first_tick;
        int steps;
        first_tick = chirp_ticks;
        while (chirp_ticks - first_tick < target) begin
            settle_pipeline();
            configure_random();
            no_gaps = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(2, 6)) begin
                send_request(1'b1);
                steps = 0;
                while (chirp_running && steps < 80) begin
                    // occasional restart mid-chirp
                    send_request($urandom_range(0, 49) == 0);
                    steps++;
                end
                repeat ($urandom_range(0, 2)) send_request(1'b0);
            end
            no_gaps = 1'b0;
        end
        settle_pipeline();
    endtask

    task automatic test_backpressure();
        set_chirp($urandom, $urandom_range(0, 65535), 32'd30);
        no_gaps     = 1'b1;
        hold_cycles = 80;
        send_request(1'b1);
        repeat (39) send_request(1'b0);
        no_gaps = 1'b0;
        settle_pipeline();
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles--;
            end else if (no_gaps) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (predicted_samples.size() == 0) begin
                $display("%0t: unexpected sample %0d active %0b last %0b",
                         $time, $signed(o_sample), o_active, o_last);
                error_count++;
            end else begin
                head_sample = predicted_samples.pop_front();
                samples_checked++;
                if (head_sample.last)
                    chirps_finished++;
                if (o_sample !== head_sample.sample) begin
                    $display("%0t: sample expected %0d got %0d", $time,
                             $signed(head_sample.sample), $signed(o_sample));
                    error_count++;
                end
                if (o_active !== head_sample.active) begin
                    $display("%0t: active expected %0b got %0b", $time,
                             head_sample.active, o_active);
                    error_count++;
                end
                if (o_last !== head_sample.last) begin
                    $display("%0t: last expected %0b got %0b", $time,
                             head_sample.last, o_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("** linear_chirp_generator: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_START_STEP;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_start_req = 1'b0;
        error_count     = 0;
        requests_sent   = 0;
        chirp_ticks     = 0;
        samples_checked = 0;
        chirps_finished = 0;
        hold_cycles     = 0;
        no_gaps         = 1'b0;
        cfg_start_step  = '0;
        cfg_step_dec    = '0;
        cfg_count       = t_count'(1);
        chirp_phase     = '0;
        chirp_step      = '0;
        chirp_left      = '0;
        chirp_running   = 1'b0;
        build_quarter_wave();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_defaults();
        test_quarter_turns();
        test_step_wrap();
        test_count_edges();
        test_ignored_register();
        test_random_chirps(2000);
        test_backpressure();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d requests (%0d chirp ticks), %0d samples checked,",
                 requests_sent, chirp_ticks, samples_checked);
        $display("%0d chirps run to their final sample, with stalls on both sides.",
                 chirps_finished);
        if (error_count == 0)
            $display("** linear_chirp_generator: PASSED **");
        else
            $display("** linear_chirp_generator: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/lcg_pkg.sv
rtl/core/lcg_sine_rom.sv
rtl/core/linear_chirp_generator.sv
tb/linear_chirp_generator_test.sv
